// File: design/inverse_multibrot_escape_time_defines.svh
// ----------------------------------------------------------------------------
// Inverse multibrot escape time - assertion macros
// Concurrent assertion helpers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INVERSE_MULTIBROT_ESCAPE_TIME_DEFINES_SVH
`define INVERSE_MULTIBROT_ESCAPE_TIME_DEFINES_SVH
`ifndef SYNTHESIS
`define IMET_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IMET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IMET_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IMET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/imet_pkg.sv
// ----------------------------------------------------------------------------
// imet_pkg
// Shared types, constants and the per-degree step program.
// ----------------------------------------------------------------------------
package imet_pkg;

  localparam int DEG_W  = 3;
  localparam int ITER_W = 16;
  localparam int CNT_W  = 17;

  localparam logic [DEG_W-1:0]  DEGREE_RESET   = 3'd2;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd256;
  localparam logic [DEG_W-1:0]  DEG_MIN        = 3'd2;
  localparam logic [DEG_W-1:0]  DEG_MAX        = 3'd5;

  localparam logic REG_DEGREE   = 1'b0;
  localparam logic REG_MAX_ITER = 1'b1;

  localparam logic [3:0] K2  = 4'd2;
  localparam logic [3:0] K3  = 4'd3;
  localparam logic [3:0] K4  = 4'd4;
  localparam logic [3:0] K5  = 4'd5;
  localparam logic [3:0] K6  = 4'd6;
  localparam logic [3:0] K10 = 4'd10;
  localparam logic [3:0] K0  = 4'd0;

  localparam logic [3:0] PC_MAG = 4'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEN, ST_ORIG, ST_DIV_RE, ST_DIV_IM, ST_INIT, ST_CHECK, ST_STEP, ST_DONE
  } imet_state_e;

  typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_SCL} imet_op_e;

  typedef enum logic [3:0] {
    RG_X, RG_Y, RG_OX, RG_OY, RG_R2, RG_I2, RG_T0, RG_T1, RG_T2, RG_T3
  } imet_reg_e;

  typedef struct packed {
    imet_op_e  op;
    imet_reg_e a;
    imet_reg_e b;
    imet_reg_e dst;
    logic [3:0] k;
    logic      last;
    logic      mag_en;
  } imet_uop_t;

  typedef struct packed {
    logic      load_in;
    logic      den_en;
    logic      zero_orig;
    logic      div_start;
    logic      div_sel;
    logic      lat_ox;
    logic      lat_oy;
    logic      init_z;
    logic      uop_en;
    imet_uop_t uop;
    logic      cnt_inc;
    logic      esc_set;
    logic      out_load;
  } imet_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic mag_gt;
    logic cnt_lt;
  } imet_sts_t;

  function automatic imet_uop_t mk(imet_op_e op, imet_reg_e a, imet_reg_e b,
                                   imet_reg_e dst, logic [3:0] k, logic last);
    imet_uop_t u;
    u.op = op; u.a = a; u.b = b; u.dst = dst; u.k = k; u.last = last; u.mag_en = 1'b0;
    return u;
  endfunction

  function automatic imet_uop_t uop_lookup(logic [1:0] dsel, logic [3:0] pc);
    imet_uop_t u;
    u = mk(OP_ADD, RG_T0, RG_T0, RG_T0, K0, 1'b1);
    case (pc)
      4'd0: u = mk(OP_MUL, RG_X, RG_X, RG_R2, K0, 1'b0);
      4'd1: u = mk(OP_MUL, RG_Y, RG_Y, RG_I2, K0, 1'b0);
      default: begin
        case (dsel)
          2'd0: begin
            case (pc)
              4'd2: u = mk(OP_MUL, RG_X,  RG_Y,  RG_T0, K0, 1'b0);
              4'd3: u = mk(OP_SUB, RG_R2, RG_I2, RG_T1, K0, 1'b0);
              4'd4: u = mk(OP_ADD, RG_T1, RG_OX, RG_X,  K0, 1'b0);
              4'd5: u = mk(OP_SCL, RG_T0, RG_T0, RG_T0, K2, 1'b0);
              4'd6: u = mk(OP_ADD, RG_T0, RG_OY, RG_Y,  K0, 1'b1);
              default: ;
            endcase
          end
          2'd1: begin
            case (pc)
              4'd2:  u = mk(OP_MUL, RG_X,  RG_R2, RG_T0, K0, 1'b0);
              4'd3:  u = mk(OP_MUL, RG_X,  RG_I2, RG_T1, K0, 1'b0);
              4'd4:  u = mk(OP_MUL, RG_Y,  RG_R2, RG_T2, K0, 1'b0);
              4'd5:  u = mk(OP_MUL, RG_Y,  RG_I2, RG_T3, K0, 1'b0);
              4'd6:  u = mk(OP_SCL, RG_T1, RG_T1, RG_T1, K3, 1'b0);
              4'd7:  u = mk(OP_SUB, RG_T0, RG_T1, RG_T0, K0, 1'b0);
              4'd8:  u = mk(OP_ADD, RG_T0, RG_OX, RG_X,  K0, 1'b0);
              4'd9:  u = mk(OP_SCL, RG_T2, RG_T2, RG_T2, K3, 1'b0);
              4'd10: u = mk(OP_SUB, RG_T2, RG_T3, RG_T2, K0, 1'b0);
              4'd11: u = mk(OP_ADD, RG_T2, RG_OY, RG_Y,  K0, 1'b1);
              default: ;
            endcase
          end
          2'd2: begin
            case (pc)
              4'd2:  u = mk(OP_MUL, RG_X,  RG_Y,  RG_T2, K0, 1'b0);
              4'd3:  u = mk(OP_MUL, RG_R2, RG_R2, RG_T0, K0, 1'b0);
              4'd4:  u = mk(OP_MUL, RG_R2, RG_I2, RG_T1, K0, 1'b0);
              4'd5:  u = mk(OP_SCL, RG_T1, RG_T1, RG_T1, K6, 1'b0);
              4'd6:  u = mk(OP_SUB, RG_T0, RG_T1, RG_T0, K0, 1'b0);
              4'd7:  u = mk(OP_MUL, RG_I2, RG_I2, RG_T1, K0, 1'b0);
              4'd8:  u = mk(OP_ADD, RG_T0, RG_T1, RG_T0, K0, 1'b0);
              4'd9:  u = mk(OP_ADD, RG_T0, RG_OX, RG_X,  K0, 1'b0);
              4'd10: u = mk(OP_SUB, RG_R2, RG_I2, RG_T3, K0, 1'b0);
              4'd11: u = mk(OP_MUL, RG_T2, RG_T3, RG_T2, K0, 1'b0);
              4'd12: u = mk(OP_SCL, RG_T2, RG_T2, RG_T2, K4, 1'b0);
              4'd13: u = mk(OP_ADD, RG_T2, RG_OY, RG_Y,  K0, 1'b1);
              default: ;
            endcase
          end
          default: begin
            case (pc)
              4'd2:  u = mk(OP_MUL, RG_R2, RG_R2, RG_T0, K0, 1'b0);
              4'd3:  u = mk(OP_MUL, RG_I2, RG_I2, RG_T1, K0, 1'b0);
              4'd4:  u = mk(OP_MUL, RG_R2, RG_I2, RG_T2, K0, 1'b0);
              4'd5:  u = mk(OP_SCL, RG_T2, RG_T2, RG_T2, K10, 1'b0);
              4'd6:  u = mk(OP_SUB, RG_T0, RG_T2, RG_T3, K0, 1'b0);
              4'd7:  u = mk(OP_SCL, RG_T1, RG_T1, RG_R2, K5, 1'b0);
              4'd8:  u = mk(OP_ADD, RG_T3, RG_R2, RG_T3, K0, 1'b0);
              4'd9:  u = mk(OP_MUL, RG_X,  RG_T3, RG_T3, K0, 1'b0);
              4'd10: u = mk(OP_ADD, RG_T3, RG_OX, RG_X,  K0, 1'b0);
              4'd11: u = mk(OP_SCL, RG_T0, RG_T0, RG_T0, K5, 1'b0);
              4'd12: u = mk(OP_SUB, RG_T0, RG_T2, RG_T0, K0, 1'b0);
              4'd13: u = mk(OP_ADD, RG_T0, RG_T1, RG_T0, K0, 1'b0);
              4'd14: u = mk(OP_MUL, RG_Y,  RG_T0, RG_T0, K0, 1'b0);
              4'd15: u = mk(OP_ADD, RG_T0, RG_OY, RG_Y,  K0, 1'b1);
              default: ;
            endcase
          end
        endcase
      end
    endcase
    u.mag_en = (pc == PC_MAG);
    return u;
  endfunction

endpackage

// File: design/imet_div.sv
// ----------------------------------------------------------------------------
// imet_div
// Restoring divider for the origin: round(num * 2^(2F) / den), one bit a cycle.
// ----------------------------------------------------------------------------
module imet_div import imet_pkg::*; #(
  parameter int FRAC_BITS = 26,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          num_i,
  input  logic [63:0]          den_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] quot_o,
  output logic                 ovf_o
);

  localparam int ND  = 32 + 2 * FRAC_BITS;
  localparam int CTW = $clog2(ND + 1);

  logic [ND-1:0]        dvd_q;
  logic [63:0]          rem_q, den_q;
  logic [WORD_BITS-1:0] q_q;
  logic                 ovf_q, busy_q, done_q;
  logic [CTW-1:0]       cnt_q;
  logic [64:0]          rem2;
  logic                 ge;
  logic [WORD_BITS:0]   qinc;
  logic                 rnd;

  assign rem2 = {rem_q, dvd_q[ND-1]};
  assign ge   = rem2 >= {1'b0, den_q};
  assign rnd  = {rem_q, 1'b0} >= {1'b0, den_q};
  assign qinc = {1'b0, q_q} + (WORD_BITS+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CTW'(ND);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CTW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, (2*FRAC_BITS)'(0)};
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        if (rnd) begin
          q_q   <= qinc[WORD_BITS-1:0];
          ovf_q <= ovf_q | qinc[WORD_BITS];
        end
      end else begin
        dvd_q <= {dvd_q[ND-2:0], 1'b0};
        rem_q <= ge ? 64'(rem2 - {1'b0, den_q}) : rem2[63:0];
        q_q   <= {q_q[WORD_BITS-2:0], ge};
        ovf_q <= ovf_q | q_q[WORD_BITS-1];
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign ovf_o  = ovf_q;

endmodule

// File: design/imet_datapath.sv
// ----------------------------------------------------------------------------
// imet_datapath
// Working registers, shared saturating ALU, origin divider and result register.
// ----------------------------------------------------------------------------
module imet_datapath import imet_pkg::*; #(
  parameter int FRAC_BITS = 26,
  parameter int WORD_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  imet_cmd_t                cmd_i,
  output imet_sts_t                sts_o,
  input  logic [ITER_W-1:0]        max_iter_i,
  input  logic signed [31:0]       coord_re_i,
  input  logic signed [31:0]       coord_im_i,
  output logic [CNT_W-1:0]         iter_count_o,
  output logic                     escaped_o,
  output logic signed [31:0]       final_re_o,
  output logic signed [31:0]       final_im_o,
  output logic [31:0]              mag_sq_o,
  output logic                     saturated_o
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int XW   = (W > 32) ? W : 33;
  localparam int MW   = (W + 1 > 33) ? W + 1 : 33;
  localparam int TW0  = (W + 1 > F + 3) ? W + 1 : F + 3;
  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] C32_MAX = XW'(32'sh7FFF_FFFF);
  localparam logic signed [XW-1:0] C32_MIN = XW'(32'sh8000_0000);

  logic signed [W-1:0] x_q, y_q, ox_q, oy_q, r2_q, i2_q, t0_q, t1_q, t2_q, t3_q;
  logic signed [31:0]  cr_q, ci_q;
  logic [63:0]         sq_q, den_q;
  logic [W:0]          mag_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                esc_q, sat_q;

  logic [31:0] ur_in, ui_q, sq_op;
  logic [63:0] sq_res;

  assign ur_in  = coord_re_i[31] ? 32'(-coord_re_i) : 32'(coord_re_i);
  assign ui_q   = ci_q[31] ? 32'(-ci_q) : 32'(ci_q);
  assign sq_op  = cmd_i.load_in ? ur_in : ui_q;
  assign sq_res = 64'(sq_op) * 64'(sq_op);

  // divider
  logic             div_done, div_ovf;
  logic [W-1:0]     div_q;
  logic [31:0]      div_num;

  assign div_num = cmd_i.div_sel ? ui_q : (cr_q[31] ? 32'(-cr_q) : 32'(cr_q));

  imet_div #(.FRAC_BITS(F), .WORD_BITS(W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (den_q),
    .done_o (div_done),
    .quot_o (div_q),
    .ovf_o  (div_ovf)
  );

  logic            dneg, dsat;
  logic [W-1:0]    dlim;
  logic signed [W-1:0] dres;

  always_comb begin
    dneg = cmd_i.lat_oy ? (!ci_q[31] && (ci_q != '0)) : cr_q[31];
    dlim = dneg ? LIM_NEG : LIM_POS;
    dsat = div_ovf || (div_q > dlim);
    if (dsat) dres = dneg ? MINW : MAXW;
    else      dres = dneg ? W'(-div_q) : W'(div_q);
  end

  // operand select
  function automatic logic signed [W-1:0] rd(imet_reg_e r, logic signed [W-1:0] vx,
      logic signed [W-1:0] vy, logic signed [W-1:0] vox, logic signed [W-1:0] voy,
      logic signed [W-1:0] vr2, logic signed [W-1:0] vi2, logic signed [W-1:0] v0,
      logic signed [W-1:0] v1, logic signed [W-1:0] v2, logic signed [W-1:0] v3);
    logic signed [W-1:0] v;
    case (r)
      RG_X:    v = vx;
      RG_Y:    v = vy;
      RG_OX:   v = vox;
      RG_OY:   v = voy;
      RG_R2:   v = vr2;
      RG_I2:   v = vi2;
      RG_T0:   v = v0;
      RG_T1:   v = v1;
      RG_T2:   v = v2;
      RG_T3:   v = v3;
      default: v = v0;
    endcase
    return v;
  endfunction

  logic signed [W-1:0] opa, opb, alu_res;
  logic                alu_sat;
  logic [W-1:0]        ma, mb, mlim;
  logic [2*W-1:0]      prod;
  logic [2*W:0]        prnd, shv;
  logic                mneg;
  logic signed [W:0]   asum;
  logic signed [W+4:0] sprod;

  assign opa = rd(cmd_i.uop.a, x_q, y_q, ox_q, oy_q, r2_q, i2_q, t0_q, t1_q, t2_q, t3_q);
  assign opb = rd(cmd_i.uop.b, x_q, y_q, ox_q, oy_q, r2_q, i2_q, t0_q, t1_q, t2_q, t3_q);

  always_comb begin
    ma    = opa[W-1] ? W'(-opa) : W'(opa);
    mb    = opb[W-1] ? W'(-opb) : W'(opb);
    mneg  = opa[W-1] ^ opb[W-1];
    prod  = (2*W)'(ma) * (2*W)'(mb);
    prnd  = (2*W+1)'(prod) + ((2*W+1)'(1) << (F - 1));
    shv   = prnd >> F;
    mlim  = mneg ? LIM_NEG : LIM_POS;
    asum  = '0;
    sprod = '0;
    alu_res = '0;
    alu_sat = 1'b0;
    case (cmd_i.uop.op)
      OP_MUL: begin
        alu_sat = shv > (2*W+1)'(mlim);
        if (alu_sat) alu_res = mneg ? MINW : MAXW;
        else         alu_res = mneg ? W'(-shv[W-1:0]) : W'(shv[W-1:0]);
      end
      OP_ADD, OP_SUB: begin
        if (cmd_i.uop.op == OP_ADD) asum = (W+1)'(opa) + (W+1)'(opb);
        else                        asum = (W+1)'(opa) - (W+1)'(opb);
        alu_sat = asum[W] != asum[W-1];
        if (alu_sat) alu_res = asum[W] ? MINW : MAXW;
        else         alu_res = asum[W-1:0];
      end
      default: begin
        sprod = (W+5)'(opa) * (W+5)'($signed({1'b0, cmd_i.uop.k}));
        if (sprod > (W+5)'(MAXW)) begin
          alu_sat = 1'b1;
          alu_res = MAXW;
        end else if (sprod < (W+5)'(MINW)) begin
          alu_sat = 1'b1;
          alu_res = MINW;
        end else begin
          alu_res = sprod[W-1:0];
        end
      end
    endcase
  end

  function automatic logic wr(imet_cmd_t c, imet_reg_e r);
    return c.uop_en && (c.uop.dst == r);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cr_q <= coord_re_i;
      ci_q <= coord_im_i;
      sq_q <= sq_res;
    end
    if (cmd_i.den_en) den_q <= sq_q + sq_res;
    if (cmd_i.zero_orig) begin
      ox_q <= MAXW;
      oy_q <= '0;
    end
    if (cmd_i.lat_ox) ox_q <= dres;
    if (cmd_i.lat_oy) oy_q <= dres;
    if (cmd_i.init_z) begin
      x_q   <= ox_q;
      y_q   <= oy_q;
      mag_q <= '0;
    end else begin
      if (wr(cmd_i, RG_X)) x_q <= alu_res;
      if (wr(cmd_i, RG_Y)) y_q <= alu_res;
      if (cmd_i.uop_en && cmd_i.uop.mag_en) mag_q <= (W+1)'(r2_q) + (W+1)'(i2_q);
    end
    if (wr(cmd_i, RG_R2)) r2_q <= alu_res;
    if (wr(cmd_i, RG_I2)) i2_q <= alu_res;
    if (wr(cmd_i, RG_T0)) t0_q <= alu_res;
    if (wr(cmd_i, RG_T1)) t1_q <= alu_res;
    if (wr(cmd_i, RG_T2)) t2_q <= alu_res;
    if (wr(cmd_i, RG_T3)) t3_q <= alu_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      esc_q <= 1'b0;
      sat_q <= 1'b0;
    end else begin
      if (cmd_i.load_in) sat_q <= 1'b0;
      else if (cmd_i.zero_orig || ((cmd_i.lat_ox || cmd_i.lat_oy) && dsat) ||
               (cmd_i.uop_en && alu_sat)) sat_q <= 1'b1;
      if (cmd_i.init_z) begin
        cnt_q <= CNT_W'(1);
        esc_q <= 1'b0;
      end else if (cmd_i.esc_set) begin
        cnt_q <= cnt_q + CNT_W'(2);
        esc_q <= 1'b1;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // output clipping and result register
  logic signed [XW-1:0] xe, ye;
  logic [MW-1:0]        me;
  logic                 xs_hi, xs_lo, ys_hi, ys_lo, ms;
  logic [TW0-1:0]       thr;

  assign xe    = XW'(x_q);
  assign ye    = XW'(y_q);
  assign me    = MW'(mag_q);
  assign xs_hi = xe > C32_MAX;
  assign xs_lo = xe < C32_MIN;
  assign ys_hi = ye > C32_MAX;
  assign ys_lo = ye < C32_MIN;
  assign ms    = me > MW'(32'hFFFF_FFFF);
  assign thr   = TW0'(4) << F;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      iter_count_o <= cnt_q;
      escaped_o    <= esc_q;
      final_re_o   <= xs_hi ? 32'sh7FFF_FFFF : (xs_lo ? 32'sh8000_0000 : xe[31:0]);
      final_im_o   <= ys_hi ? 32'sh7FFF_FFFF : (ys_lo ? 32'sh8000_0000 : ye[31:0]);
      mag_sq_o     <= ms ? 32'hFFFF_FFFF : me[31:0];
      saturated_o  <= sat_q | xs_hi | xs_lo | ys_hi | ys_lo | ms;
    end
  end

  assign sts_o.den_zero = (den_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.mag_gt   = TW0'(mag_q) > thr;
  assign sts_o.cnt_lt   = cnt_q < {1'b0, max_iter_i};

endmodule

// File: design/imet_ctrl.sv
// ----------------------------------------------------------------------------
// imet_ctrl
// Sequencer: origin setup, step program per degree, escape tail, handoff.
// ----------------------------------------------------------------------------
module imet_ctrl import imet_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DEG_W-1:0] degree_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  imet_sts_t        sts_i,
  output imet_cmd_t        cmd_o
);

  imet_state_e state_q, state_d;
  logic [3:0]  pc_q;
  logic        tail_q;
  logic [1:0]  extra_q;
  logic        out_valid_q;
  logic [1:0]  dsel;
  imet_uop_t   uop;
  logic        slot_free;

  always_comb begin
    if (degree_i < DEG_MIN)      dsel = 2'd0;
    else if (degree_i > DEG_MAX) dsel = 2'd3;
    else                         dsel = 2'(degree_i - DEG_MIN);
  end

  assign uop       = uop_lookup(dsel, pc_q);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DEN;
      ST_DEN:    state_d = ST_ORIG;
      ST_ORIG:   state_d = sts_i.den_zero ? ST_INIT : ST_DIV_RE;
      ST_DIV_RE: if (sts_i.div_done) state_d = ST_DIV_IM;
      ST_DIV_IM: if (sts_i.div_done) state_d = ST_INIT;
      ST_INIT:   state_d = ST_CHECK;
      ST_CHECK:  state_d = sts_i.cnt_lt ? ST_STEP : ST_DONE;
      ST_STEP: begin
        if (uop.last) begin
          if (!tail_q) state_d = sts_i.mag_gt ? ST_STEP : ST_CHECK;
          else if (extra_q == 2'd1) state_d = ST_DONE;
        end
      end
      ST_DONE:   if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.uop  = uop;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_DEN:  cmd_o.den_en = 1'b1;
      ST_ORIG: begin
        cmd_o.zero_orig = sts_i.den_zero;
        cmd_o.div_start = !sts_i.den_zero;
      end
      ST_DIV_RE: begin
        cmd_o.lat_ox    = sts_i.div_done;
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_sel   = sts_i.div_done;
      end
      ST_DIV_IM: begin
        cmd_o.div_sel = 1'b1;
        cmd_o.lat_oy  = sts_i.div_done;
      end
      ST_INIT: cmd_o.init_z = 1'b1;
      ST_STEP: begin
        cmd_o.uop_en  = 1'b1;
        cmd_o.esc_set = uop.last && !tail_q && sts_i.mag_gt;
        cmd_o.cnt_inc = uop.last && !tail_q && !sts_i.mag_gt;
      end
      ST_DONE: cmd_o.out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      tail_q      <= 1'b0;
      extra_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT) begin
        tail_q  <= 1'b0;
        extra_q <= '0;
      end
      if (state_q == ST_CHECK) pc_q <= '0;
      if (state_q == ST_STEP) begin
        if (uop.last) begin
          pc_q <= '0;
          if (!tail_q) begin
            if (sts_i.mag_gt) begin
              tail_q  <= 1'b1;
              extra_q <= 2'd2;
            end
          end else begin
            extra_q <= extra_q - 2'd1;
          end
        end else begin
          pc_q <= pc_q + 4'd1;
        end
      end
      if (cmd_o.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/inverse_multibrot_escape_time.sv
// Origin setup: two serial divides (skipped when c is zero), then per iteration the
// step program for degree 2/3/4/5 plus a check state.
// One pixel at a time: next pixel accepted once the result is handed to the output register.
// Rate set by the shared ALU running one multiply or add per cycle.
// Reset: asynchronous active low; degree 2, max_iter 256, no result pending.
// ----------------------------------------------------------------------------
// inverse_multibrot_escape_time
// Escape-time evaluator for z := z^d + 1/c with APB configuration.
// ----------------------------------------------------------------------------
`include "inverse_multibrot_escape_time_defines.svh"
module inverse_multibrot_escape_time import imet_pkg::*; #(
  parameter int FRAC_BITS = 26,
  parameter int WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] coord_re_i,
  input  logic signed [31:0] coord_im_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CNT_W-1:0]   iter_count_o,
  output logic               escaped_o,
  output logic signed [31:0] final_re_o,
  output logic signed [31:0] final_im_o,
  output logic [31:0]        mag_sq_o,
  output logic               saturated_o
);

  logic [DEG_W-1:0]  degree_q;
  logic [ITER_W-1:0] max_iter_q;
  imet_cmd_t         cmd;
  imet_sts_t         sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q   <= DEGREE_RESET;
      max_iter_q <= MAX_ITER_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DEGREE:   degree_q   <= pwdata[DEG_W-1:0];
        REG_MAX_ITER: max_iter_q <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEGREE:   prdata = 32'(degree_q);
      REG_MAX_ITER: prdata = 32'(max_iter_q);
      default:      prdata = '0;
    endcase
  end

  imet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .degree_i   (degree_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  imet_datapath #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .max_iter_i  (max_iter_q),
    .coord_re_i  (coord_re_i),
    .coord_im_i  (coord_im_i),
    .iter_count_o(iter_count_o),
    .escaped_o   (escaped_o),
    .final_re_o  (final_re_o),
    .final_im_o  (final_im_o),
    .mag_sq_o    (mag_sq_o),
    .saturated_o (saturated_o)
  );

  `IMET_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `IMET_ASSERT_IMPL(a_escape_count, clk_i, rst_ni, out_valid_o && escaped_o, iter_count_o >= 17'd3)
  `IMET_ASSERT_IMPL(a_single_action, clk_i, rst_ni, cmd.esc_set, !cmd.cnt_inc && cmd.uop_en)

endmodule
